// File: sv/ctlt_pkg.sv
// Shared types, character codes and token kinds of the C-style source tokenizer.
`timescale 1ns / 1ps

package ctlt_pkg;

  localparam int PosBits = 16;

  localparam int KindBits = 5;
  localparam int OffBits  = 16;
  localparam int LenBits  = 16;

  localparam logic [KindBits-1:0] KindUnknown = 5'd0;
  localparam logic [KindBits-1:0] KindLParen  = 5'd1;
  localparam logic [KindBits-1:0] KindRParen  = 5'd2;
  localparam logic [KindBits-1:0] KindLess    = 5'd3;
  localparam logic [KindBits-1:0] KindGreater = 5'd4;
  localparam logic [KindBits-1:0] KindSemi    = 5'd5;
  localparam logic [KindBits-1:0] KindStar    = 5'd6;
  localparam logic [KindBits-1:0] KindAmp     = 5'd7;
  localparam logic [KindBits-1:0] KindLBrace  = 5'd8;
  localparam logic [KindBits-1:0] KindRBrace  = 5'd9;
  localparam logic [KindBits-1:0] KindLBrack  = 5'd10;
  localparam logic [KindBits-1:0] KindRBrack  = 5'd11;
  localparam logic [KindBits-1:0] KindEnd     = 5'd12;
  localparam logic [KindBits-1:0] KindHash    = 5'd13;
  localparam logic [KindBits-1:0] KindComma   = 5'd14;
  localparam logic [KindBits-1:0] KindEqual   = 5'd15;
  localparam logic [KindBits-1:0] KindColon   = 5'd16;
  localparam logic [KindBits-1:0] KindDColon  = 5'd17;
  localparam logic [KindBits-1:0] KindString  = 5'd18;
  localparam logic [KindBits-1:0] KindIdent   = 5'd19;
  localparam logic [KindBits-1:0] KindNumber  = 5'd20;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChVt     = 8'h0B;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChLowerF = 8'h66;

  typedef enum logic [9:0] {
    ModeIdle      = 10'b00_0000_0001,
    ModeSlash     = 10'b00_0000_0010,
    ModeLine      = 10'b00_0000_0100,
    ModeBlock     = 10'b00_0000_1000,
    ModeBlockStar = 10'b00_0001_0000,
    ModeColon     = 10'b00_0010_0000,
    ModeString    = 10'b00_0100_0000,
    ModeEscape    = 10'b00_1000_0000,
    ModeIdent     = 10'b01_0000_0000,
    ModeNumber    = 10'b10_0000_0000
  } mode_e;

  typedef struct packed {
    mode_e               mode;
    logic [OffBits-1:0]  pend_start;
    logic [LenBits-1:0]  pend_len;
    logic                dec_seen;
    logic [PosBits-1:0]  pos;
  } scan_t;

  typedef struct packed {
    logic [KindBits-1:0] kind;
    logic [OffBits-1:0]  start;
    logic [LenBits-1:0]  length;
    logic                last;
  } token_t;

  localparam int TdataBits = ((KindBits + OffBits + LenBits + 7) / 8) * 8;

  function automatic logic [KindBits-1:0] punct_kind(input logic [7:0] c);
    logic [KindBits-1:0] k;
    case (c)
      8'h28:   k = KindLParen;
      8'h29:   k = KindRParen;
      8'h3C:   k = KindLess;
      8'h3E:   k = KindGreater;
      8'h3B:   k = KindSemi;
      8'h2A:   k = KindStar;
      8'h26:   k = KindAmp;
      8'h7B:   k = KindLBrace;
      8'h7D:   k = KindRBrace;
      8'h5B:   k = KindLBrack;
      8'h5D:   k = KindRBrack;
      8'h23:   k = KindHash;
      8'h2C:   k = KindComma;
      8'h3D:   k = KindEqual;
      default: k = KindUnknown;
    endcase
    return k;
  endfunction

  function automatic logic [LenBits-1:0] sat_inc(input logic [LenBits-1:0] v);
    return (v == {LenBits{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [OffBits-1:0] pos_to_off(input logic [PosBits-1:0] p);
    logic [31:0] ext;
    ext = 32'(p);
    return ext[OffBits-1:0];
  endfunction

endpackage

// File: sv/ctlt_step.sv
// Next-state and token logic of the tokenizer for one source byte.
`timescale 1ns / 1ps

module ctlt_step (
  input  ctlt_pkg::scan_t  cur_i,
  input  logic [7:0]       char_i,
  output ctlt_pkg::scan_t  nxt_o,
  output logic [1:0]       count_o,
  output ctlt_pkg::token_t tok0_o,
  output ctlt_pkg::token_t tok1_o
);

  logic                          rp;
  logic                          pv;
  logic                          rv;
  ctlt_pkg::token_t              pt;
  ctlt_pkg::token_t              rt;
  logic [ctlt_pkg::KindBits-1:0] k;
  logic                          is_space;
  logic                          is_alpha;
  logic                          is_digit;
  logic [ctlt_pkg::OffBits-1:0]  pos_off;
  logic [ctlt_pkg::PosBits-1:0]  pos_inc;

  assign is_space = (char_i == ctlt_pkg::ChSpace) || (char_i == ctlt_pkg::ChTab) ||
                    (char_i == ctlt_pkg::ChLf) || (char_i == ctlt_pkg::ChCr) ||
                    (char_i == ctlt_pkg::ChVt) || (char_i == ctlt_pkg::ChFf);
  assign is_alpha = (char_i >= 8'h61 && char_i <= 8'h7A) || (char_i >= 8'h41 && char_i <= 8'h5A);
  assign is_digit = (char_i >= 8'h30 && char_i <= 8'h39);
  assign pos_off  = ctlt_pkg::pos_to_off(cur_i.pos);
  assign pos_inc  = cur_i.pos + 1'b1;
  assign k        = ctlt_pkg::punct_kind(char_i);

  always_comb begin
    nxt_o     = cur_i;
    nxt_o.pos = pos_inc;
    rp        = 1'b0;
    pv        = 1'b0;
    pt        = '0;
    rv        = 1'b0;
    rt        = '0;

    case (cur_i.mode)
      ctlt_pkg::ModeSlash: begin
        if (char_i == ctlt_pkg::ChSlash) begin
          nxt_o.mode = ctlt_pkg::ModeLine;
        end else if (char_i == ctlt_pkg::ChStar) begin
          nxt_o.mode = ctlt_pkg::ModeBlock;
        end else begin
          pv = 1'b1;
          pt = '{ctlt_pkg::KindUnknown, cur_i.pend_start, 16'd1, 1'b0};
          rp = 1'b1;
        end
      end
      ctlt_pkg::ModeLine: begin
        if (char_i == ctlt_pkg::ChNul || char_i == ctlt_pkg::ChLf ||
            char_i == ctlt_pkg::ChCr) begin
          rp = 1'b1;
        end
      end
      ctlt_pkg::ModeBlock: begin
        if (char_i == ctlt_pkg::ChNul) begin
          rp = 1'b1;
        end else if (char_i == ctlt_pkg::ChStar) begin
          nxt_o.mode = ctlt_pkg::ModeBlockStar;
        end
      end
      ctlt_pkg::ModeBlockStar: begin
        if (char_i == ctlt_pkg::ChNul) begin
          rp = 1'b1;
        end else if (char_i == ctlt_pkg::ChSlash) begin
          nxt_o.mode = ctlt_pkg::ModeIdle;
        end else if (char_i != ctlt_pkg::ChStar) begin
          nxt_o.mode = ctlt_pkg::ModeBlock;
        end
      end
      ctlt_pkg::ModeColon: begin
        pv = 1'b1;
        if (char_i == ctlt_pkg::ChColon) begin
          pt = '{ctlt_pkg::KindDColon, cur_i.pend_start, 16'd2, 1'b0};
          nxt_o.mode = ctlt_pkg::ModeIdle;
        end else begin
          pt = '{ctlt_pkg::KindColon, cur_i.pend_start, 16'd1, 1'b0};
          rp = 1'b1;
        end
      end
      ctlt_pkg::ModeString: begin
        if (char_i == ctlt_pkg::ChNul || char_i == ctlt_pkg::ChQuote) begin
          pv = 1'b1;
          pt = '{ctlt_pkg::KindString, cur_i.pend_start, cur_i.pend_len, 1'b0};
          if (char_i == ctlt_pkg::ChNul) begin
            rp = 1'b1;
          end else begin
            nxt_o.mode = ctlt_pkg::ModeIdle;
          end
        end else begin
          nxt_o.pend_len = ctlt_pkg::sat_inc(cur_i.pend_len);
          if (char_i == ctlt_pkg::ChBslash) begin
            nxt_o.mode = ctlt_pkg::ModeEscape;
          end
        end
      end
      ctlt_pkg::ModeEscape: begin
        if (char_i == ctlt_pkg::ChNul) begin
          pv = 1'b1;
          pt = '{ctlt_pkg::KindString, cur_i.pend_start, cur_i.pend_len, 1'b0};
          rp = 1'b1;
        end else begin
          nxt_o.pend_len = ctlt_pkg::sat_inc(cur_i.pend_len);
          nxt_o.mode     = ctlt_pkg::ModeString;
        end
      end
      ctlt_pkg::ModeIdent: begin
        if (is_alpha || is_digit || char_i == ctlt_pkg::ChUnder) begin
          nxt_o.pend_len = ctlt_pkg::sat_inc(cur_i.pend_len);
        end else begin
          pv = 1'b1;
          pt = '{ctlt_pkg::KindIdent, cur_i.pend_start, cur_i.pend_len, 1'b0};
          rp = 1'b1;
        end
      end
      ctlt_pkg::ModeNumber: begin
        if (is_digit || char_i == ctlt_pkg::ChLowerF ||
            (char_i == ctlt_pkg::ChDot && !cur_i.dec_seen)) begin
          if (char_i == ctlt_pkg::ChDot) begin
            nxt_o.dec_seen = 1'b1;
          end
          nxt_o.pend_len = ctlt_pkg::sat_inc(cur_i.pend_len);
        end else begin
          pv = 1'b1;
          pt = '{ctlt_pkg::KindNumber, cur_i.pend_start, cur_i.pend_len, 1'b0};
          rp = 1'b1;
        end
      end
      default: begin
        rp = 1'b1;
      end
    endcase

    if (rp) begin
      nxt_o.mode = ctlt_pkg::ModeIdle;
      if (char_i == ctlt_pkg::ChNul) begin
        rv = 1'b1;
        rt = '{ctlt_pkg::KindEnd, pos_off, 16'd1, 1'b0};
        nxt_o.mode       = ctlt_pkg::ModeIdle;
        nxt_o.pend_start = '0;
        nxt_o.pend_len   = '0;
        nxt_o.dec_seen   = 1'b0;
        nxt_o.pos        = '0;
      end else if (is_space) begin
        rv = 1'b0;
      end else if (k != ctlt_pkg::KindUnknown) begin
        rv = 1'b1;
        rt = '{k, pos_off, 16'd1, 1'b0};
      end else if (char_i == ctlt_pkg::ChSlash) begin
        nxt_o.mode       = ctlt_pkg::ModeSlash;
        nxt_o.pend_start = pos_off;
      end else if (char_i == ctlt_pkg::ChColon) begin
        nxt_o.mode       = ctlt_pkg::ModeColon;
        nxt_o.pend_start = pos_off;
      end else if (char_i == ctlt_pkg::ChQuote) begin
        nxt_o.mode       = ctlt_pkg::ModeString;
        nxt_o.pend_start = ctlt_pkg::pos_to_off(pos_inc);
        nxt_o.pend_len   = '0;
      end else if (is_alpha) begin
        nxt_o.mode       = ctlt_pkg::ModeIdent;
        nxt_o.pend_start = pos_off;
        nxt_o.pend_len   = 16'd1;
      end else if (is_digit || char_i == ctlt_pkg::ChMinus) begin
        nxt_o.mode       = ctlt_pkg::ModeNumber;
        nxt_o.pend_start = pos_off;
        nxt_o.pend_len   = 16'd1;
        nxt_o.dec_seen   = 1'b0;
      end else begin
        rv = 1'b1;
        rt = '{ctlt_pkg::KindUnknown, pos_off, 16'd1, 1'b0};
      end
    end

    // The first token leads; the second slot only matters when both fire.
    tok0_o      = pv ? pt : rt;
    tok0_o.last = !(pv && rv);
    tok1_o      = rt;
    tok1_o.last = 1'b1;
    count_o     = {1'b0, pv} + {1'b0, rv};
  end

endmodule

// File: sv/c_like_source_tokenizer.sv
// Top level of the C-style source tokenizer: byte register, scan state and token queue.
//
//  channel  | dir | tdata (low bit up)                          | tlast
//  s_axis   | in  | char_byte[7:0]                              | -
//  m_axis   | out | token_kind[4:0], token_start[20:5],          | last_of_run
//           |     | token_length[36:21], zeros[39:37]           |
//
// One source byte is taken per cycle unless the byte register holds; a byte is scanned
// from the byte register. A byte may give up to two tokens, which leave one per cycle
// from a four-word queue while m_axis_tready_i is high; two-token bytes fill it faster.
// The byte register holds while the queue has fewer than two free words.
// Reset clears the scan state, the byte position and the queue; a 0 byte also
// returns the scan state to reset after its end token.
`timescale 1ns / 1ps

module c_like_source_tokenizer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,   // char_byte
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [ctlt_pkg::TdataBits-1:0] m_axis_tdata_o,   // token_kind, token_start,
                                                           // token_length
  output logic                           m_axis_tlast_o    // last_of_run
);

  localparam int PadBits = ctlt_pkg::TdataBits - ctlt_pkg::KindBits -
                           ctlt_pkg::OffBits - ctlt_pkg::LenBits;

  logic             byte_vld_q;
  logic             byte_vld_d;
  logic [7:0]       char_q;
  ctlt_pkg::scan_t  scan_q;
  ctlt_pkg::scan_t  scan_d;
  logic [1:0]       count;
  ctlt_pkg::token_t tok0;
  ctlt_pkg::token_t tok1;
  logic             consume;
  logic             pop;
  logic             push;
  ctlt_pkg::token_t fifo_q [4];
  logic [1:0]       wr_ptr_q;
  logic [1:0]       wr_ptr_d;
  logic [1:0]       rd_ptr_q;
  logic [1:0]       rd_ptr_d;
  logic [2:0]       fill_q;
  logic [2:0]       fill_d;
  logic [1:0]       wr_ptr_inc;
  ctlt_pkg::token_t head;

  ctlt_step u_step (
    .cur_i   (scan_q),
    .char_i  (char_q),
    .nxt_o   (scan_d),
    .count_o (count),
    .tok0_o  (tok0),
    .tok1_o  (tok1)
  );

  assign consume         = byte_vld_q && (fill_q <= 3'd2);
  assign s_axis_tready_o = !byte_vld_q || consume;
  assign byte_vld_d      = s_axis_tready_o ? s_axis_tvalid_i : byte_vld_q;
  assign push            = consume && (count != 2'd0);
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;
  assign wr_ptr_inc      = wr_ptr_q + 2'd1;

  assign wr_ptr_d = consume ? wr_ptr_q + count : wr_ptr_q;
  assign rd_ptr_d = pop ? rd_ptr_q + 2'd1 : rd_ptr_q;
  assign fill_d   = fill_q + (consume ? {1'b0, count} : 3'd0) - {2'b0, pop};

  assign head            = fifo_q[rd_ptr_q];
  assign m_axis_tvalid_o = (fill_q != 3'd0);
  assign m_axis_tdata_o  = {{PadBits{1'b0}}, head.length, head.start, head.kind};
  assign m_axis_tlast_o  = head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q        <= 1'b0;
      scan_q.mode       <= ctlt_pkg::ModeIdle;
      scan_q.pend_start <= '0;
      scan_q.pend_len   <= '0;
      scan_q.dec_seen   <= 1'b0;
      scan_q.pos        <= '0;
      wr_ptr_q          <= '0;
      rd_ptr_q          <= '0;
      fill_q            <= '0;
    end else begin
      byte_vld_q <= byte_vld_d;
      if (consume) begin
        scan_q <= scan_d;
      end
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      char_q <= s_axis_tdata_i;
    end
    if (push) begin
      fifo_q[wr_ptr_q] <= tok0;
      if (count == 2'd2) begin
        fifo_q[wr_ptr_inc] <= tok1;
      end
    end
  end

endmodule
